FILE: src/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 14;
  localparam int DELAY_W   = 24;
  localparam int FRAC_W    = 8;
  localparam int WEIGHT_W  = FRAC_W + 1;
  localparam int OFFSET_W  = 16;
  localparam int GAINED_W  = 27;
  localparam int ACC_W     = 34;
  localparam int WIDE_W    = 42;
  localparam int CFG_IDX_W = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << FRAC_W);

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd2;

  localparam logic [GAIN_W-1:0] INPUT_GAIN_RST    = 16'd16384;
  localparam logic [GAIN_W-1:0] FEEDBACK_GAIN_RST = 16'd14746;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_SCALE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;

  localparam wide_t SAT_MAX = 42'sd8388607;
  localparam wide_t SAT_MIN = -42'sd8388608;

  typedef struct packed {
    logic rd;
    logic ld_s1;
    logic ld_acc;
    logic ld_y;
    logic wr_clr;
    logic wr_fb;
    logic wr_op;
    logic op_scale;
    logic ip_is_wp;
    logic nx_is_wp;
  } lane_ctrl_t;

  function automatic sample_t sat_sample(wide_t v);
    sample_t r;
    if (v > SAT_MAX) begin
      r = SAMPLE_W'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      r = SAMPLE_W'(SAT_MIN);
    end else begin
      r = SAMPLE_W'(v);
    end
    return r;
  endfunction

  function automatic wide_t rnd_shr(wide_t v, int unsigned sh);
    wide_t half;
    half = wide_t'(1) <<< (sh - 1);
    return (v + half) >>> sh;
  endfunction

endpackage

FILE: src/stereo_fractional_feedback_delay_unit.sv
`timescale 1ns / 1ps
// channel  | direction | handshake              | payload
// in       | to block  | in_valid_i/in_stall_o  | mode, sample_in, out_gain, stereo,
//          |           |                        | offset, channel, coefficient
// out      | from block| out_valid_o/out_stall_i| left_out, right_out
// cfg      | to block  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Tick: reduction of the delay (S steps), address, three reads, tap, feedback write and result;
// add or scale: reduction of the offset, address, read, store write; S = 1 for BUFFER_DEPTH >= 32768.
// The single read port of each sample memory sets the tick length (three reads).
// After reset a clearing pass writes zero over every entry of the stores with in_stall_o
// high; configuration writes are taken at all times.
// A finished result waits in the output register; the next item is taken meanwhile.
module stereo_fractional_feedback_delay_unit #(
  parameter int unsigned BUFFER_DEPTH = 65536
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            mode_i,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0]   sample_in_i,
  input  logic [sfd_pkg::GAIN_W-1:0]            out_gain_i,
  input  logic                                  stereo_i,
  input  logic [sfd_pkg::OFFSET_W-1:0]          offset_i,
  input  logic                                  channel_i,
  input  logic [sfd_pkg::GAIN_W-1:0]            coefficient_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [sfd_pkg::SAMPLE_W-1:0]   left_out_o,
  output logic signed [sfd_pkg::SAMPLE_W-1:0]   right_out_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [sfd_pkg::DELAY_W-1:0]           cfg_data_i
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(BUFFER_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(BUFFER_DEPTH);

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_MOD   = 10'b0000000100,
    ST_ADR   = 10'b0000001000,
    ST_RWP   = 10'b0000010000,
    ST_RIP   = 10'b0000100000,
    ST_RNX   = 10'b0001000000,
    ST_TAP   = 10'b0010000000,
    ST_FB    = 10'b0100000000,
    ST_OP    = 10'b1000000000
  } state_e;

  function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] a);
    logic [AW-1:0] r;
    if (a == LAST) begin
      r = '0;
    end else begin
      r = a + 1'b1;
    end
    return r;
  endfunction

  state_e state_q, state_d;
  logic [AW-1:0] wp_q, wp_d, clr_q, clr_d;
  logic [sfd_pkg::DELAY_W-1:0] dl_q;
  logic [sfd_pkg::GAIN_W-1:0]  ig_q, fg_q;
  logic out_valid_q, out_valid_d;
  sfd_pkg::sample_t left_q, right_q;

  sfd_pkg::mode_e mode_q;
  sfd_pkg::sample_t x_q;
  logic [sfd_pkg::GAIN_W-1:0] og_q, coef_q;
  logic stereo_q, chan_q, step_q;
  logic [sfd_pkg::FRAC_W-1:0] frac_q;
  logic [AW-1:0] red_q, ptr_q, nx_q, ptr_d;
  logic ip_wp_q, nx_wp_q;
  logic signed [sfd_pkg::GAINED_W-1:0] g_q;

  logic in_fire, tick_q, out_free, mr_start, mr_done;
  logic [sfd_pkg::OFFSET_W-1:0] mr_value;
  logic [AW-1:0] mr_rem, rd_addr, wr_addr;
  logic [AW:0] sub_w, diff_w, ip_w, sum_w, idx_w;
  sfd_pkg::wide_t gain_prod;
  sfd_pkg::lane_ctrl_t ctrl_l, ctrl_r;
  sfd_pkg::sample_t lane_l_out, lane_r_out;

  assign in_stall_o  = state_q != ST_IDLE;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;
  assign tick_q      = mode_q == sfd_pkg::MODE_TICK;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign mr_start = in_fire && (sfd_pkg::mode_e'(mode_i) != sfd_pkg::MODE_NONE);
  assign mr_value = (sfd_pkg::mode_e'(mode_i) == sfd_pkg::MODE_TICK)
                    ? dl_q[sfd_pkg::DELAY_W-1:sfd_pkg::FRAC_W] : offset_i;

  sfd_modred #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_modred (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mr_start),
    .value_i (mr_value),
    .done_o  (mr_done),
    .rem_o   (mr_rem)
  );

  assign gain_prod = x_q * $signed({1'b0, ig_q});

  assign sub_w  = {1'b0, red_q} + (AW + 1)'(step_q);
  assign diff_w = {1'b0, wp_q} - sub_w;
  assign ip_w   = ({1'b0, wp_q} < sub_w) ? diff_w + DEPTH_W : diff_w;
  assign sum_w  = {1'b0, wp_q} + {1'b0, red_q};
  assign idx_w  = (sum_w >= DEPTH_W) ? sum_w - DEPTH_W : sum_w;
  assign ptr_d  = tick_q ? AW'(ip_w) : AW'(idx_w);

  always_comb begin
    case (state_q)
      ST_RWP:  rd_addr = tick_q ? wp_q : ptr_q;
      ST_RIP:  rd_addr = ptr_q;
      default: rd_addr = nx_q;
    endcase
    case (state_q)
      ST_CLEAR: wr_addr = clr_q;
      ST_FB:    wr_addr = wp_q;
      default:  wr_addr = ptr_q;
    endcase
  end

  always_comb begin
    ctrl_l          = '0;
    ctrl_l.rd       = (state_q == ST_RWP) || (state_q == ST_RIP) || (state_q == ST_RNX);
    ctrl_l.ld_s1    = state_q == ST_RIP;
    ctrl_l.ld_acc   = state_q == ST_RNX;
    ctrl_l.ld_y     = state_q == ST_TAP;
    ctrl_l.wr_clr   = state_q == ST_CLEAR;
    ctrl_l.op_scale = mode_q == sfd_pkg::MODE_SCALE;
    ctrl_l.ip_is_wp = ip_wp_q;
    ctrl_l.nx_is_wp = nx_wp_q;
    ctrl_r          = ctrl_l;
    ctrl_l.wr_fb    = (state_q == ST_FB) && out_free;
    ctrl_r.wr_fb    = (state_q == ST_FB) && out_free && stereo_q;
    ctrl_l.wr_op    = (state_q == ST_OP) && !chan_q;
    ctrl_r.wr_op    = (state_q == ST_OP) && chan_q;
  end

  sfd_lane #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_lane_l (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl_l),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .gained_i   (g_q),
    .frac_i     (frac_q),
    .fb_gain_i  (fg_q),
    .out_gain_i (og_q),
    .coef_i     (coef_q),
    .out_o      (lane_l_out)
  );

  sfd_lane #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_lane_r (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl_r),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .gained_i   (g_q),
    .frac_i     (frac_q),
    .fb_gain_i  (fg_q),
    .out_gain_i (og_q),
    .coef_i     (coef_q),
    .out_o      (lane_r_out)
  );

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (mr_start) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mr_done) begin
          state_d = ST_ADR;
        end
      end
      ST_ADR: state_d = ST_RWP;
      ST_RWP: state_d = tick_q ? ST_RIP : ST_OP;
      ST_RIP: state_d = ST_RNX;
      ST_RNX: state_d = ST_TAP;
      ST_TAP: state_d = ST_FB;
      ST_FB: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          wp_d        = wrap_inc(wp_q);
          out_valid_d = 1'b1;
        end
      end
      ST_OP:   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      wp_q        <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      dl_q        <= '0;
      ig_q        <= sfd_pkg::INPUT_GAIN_RST;
      fg_q        <= sfd_pkg::FEEDBACK_GAIN_RST;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          sfd_pkg::CFG_DELAY_LENGTH:  dl_q <= cfg_data_i;
          sfd_pkg::CFG_INPUT_GAIN:    ig_q <= cfg_data_i[sfd_pkg::GAIN_W-1:0];
          sfd_pkg::CFG_FEEDBACK_GAIN: fg_q <= cfg_data_i[sfd_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q   <= sfd_pkg::mode_e'(mode_i);
      x_q      <= sample_in_i;
      og_q     <= out_gain_i;
      stereo_q <= stereo_i;
      chan_q   <= channel_i;
      coef_q   <= coefficient_i;
      frac_q   <= sfd_pkg::FRAC_W'(0) - dl_q[sfd_pkg::FRAC_W-1:0];
      step_q   <= |dl_q[sfd_pkg::FRAC_W-1:0];
    end
    if (state_q == ST_MOD) begin
      red_q <= mr_rem;
      g_q   <= sfd_pkg::GAINED_W'(sfd_pkg::rnd_shr(gain_prod, sfd_pkg::GAIN_FRAC));
    end
    if (state_q == ST_ADR) begin
      ptr_q <= ptr_d;
    end
    if (state_q == ST_RWP) begin
      nx_q    <= wrap_inc(ptr_q);
      ip_wp_q <= ptr_q == wp_q;
    end
    if (state_q == ST_RIP) begin
      nx_wp_q <= nx_q == wp_q;
    end
    if ((state_q == ST_FB) && out_free) begin
      left_q  <= lane_l_out;
      right_q <= stereo_q ? lane_r_out : '0;
    end
  end

  a_out_from_fb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FB)
    else $error("result appeared outside the feedback step");

  a_wp_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(wp_q) |-> $past(state_q) == ST_FB)
    else $error("write position moved outside a tick");

  a_red_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mr_done |-> state_q == ST_MOD)
    else $error("reduction finished outside its wait state");

  a_mono_right_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) && !stereo_q |-> right_q == '0)
    else $error("mono tick produced nonzero right output");

endmodule

FILE: src/sfd_modred.sv
`timescale 1ns / 1ps

module sfd_modred #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sfd_pkg::OFFSET_W-1:0]  value_i,
  output logic                          done_o,
  output logic [AW-1:0]                 rem_o
);

  localparam int unsigned VALUE_MAX = (1 << sfd_pkg::OFFSET_W) - 1;

  function automatic int unsigned top_shift(int unsigned d);
    int unsigned k;
    k = 0;
    while ((d << (k + 1)) <= VALUE_MAX) k = k + 1;
    return k;
  endfunction

  localparam int unsigned K  = top_shift(DEPTH);
  localparam int unsigned KW = $clog2(K + 2);
  localparam int unsigned CW = (AW + 1 > sfd_pkg::OFFSET_W + 1) ? AW + 1 : sfd_pkg::OFFSET_W + 1;
  localparam logic [CW-1:0] MODULUS = CW'(DEPTH);
  localparam logic [KW-1:0] K_INIT  = KW'(K);

  logic                         busy_q, busy_d;
  logic [KW-1:0]                k_q, k_d;
  logic [sfd_pkg::OFFSET_W-1:0] rem_q, rem_d, rem_step;
  logic [CW-1:0]                trial, diff;
  logic                         fits;

  assign trial    = MODULUS << k_q;
  assign fits     = CW'(rem_q) >= trial;
  assign diff     = CW'(rem_q) - trial;
  assign rem_step = fits ? sfd_pkg::OFFSET_W'(diff) : rem_q;
  assign done_o   = busy_q && (k_q == '0);
  assign rem_o    = AW'(rem_step);

  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      k_d    = K_INIT;
      rem_d  = value_i;
    end else if (busy_q) begin
      rem_d = rem_step;
      if (k_q == '0) begin
        busy_d = 1'b0;
      end else begin
        k_d = k_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

endmodule

FILE: src/sfd_lane.sv
`timescale 1ns / 1ps

module sfd_lane #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                                clk_i,
  input  sfd_pkg::lane_ctrl_t                 ctrl_i,
  input  logic [AW-1:0]                       rd_addr_i,
  input  logic [AW-1:0]                       wr_addr_i,
  input  logic signed [sfd_pkg::GAINED_W-1:0] gained_i,
  input  logic [sfd_pkg::FRAC_W-1:0]          frac_i,
  input  logic [sfd_pkg::GAIN_W-1:0]          fb_gain_i,
  input  logic [sfd_pkg::GAIN_W-1:0]          out_gain_i,
  input  logic [sfd_pkg::GAIN_W-1:0]          coef_i,
  output sfd_pkg::sample_t                    out_o
);

  sfd_pkg::sample_t mem_q [DEPTH];

  sfd_pkg::sample_t rdata_q, s1_q, y_q;
  sfd_pkg::sample_t s1_d, y_d, ip_src, nx_src, fb_new, scaled, wdata;
  logic signed [sfd_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [sfd_pkg::WEIGHT_W-1:0]     w_ip;
  sfd_pkg::wide_t                   in_sum, tap_sum, fb_prod, fb_sum, og_prod, sc_prod;
  logic                             we;

  assign ip_src = ctrl_i.ip_is_wp ? s1_q : rdata_q;
  assign nx_src = ctrl_i.nx_is_wp ? s1_q : rdata_q;
  assign w_ip   = sfd_pkg::WEIGHT_ONE - {1'b0, frac_i};

  assign in_sum  = rdata_q + gained_i;
  assign s1_d    = sfd_pkg::sat_sample(in_sum);
  assign acc_d   = ip_src * $signed({1'b0, w_ip});
  assign tap_sum = acc_q + nx_src * $signed({1'b0, frac_i});
  assign y_d     = sfd_pkg::sat_sample(sfd_pkg::rnd_shr(tap_sum, sfd_pkg::FRAC_W));

  assign fb_prod = y_q * $signed({1'b0, fb_gain_i});
  assign fb_sum  = s1_q + sfd_pkg::rnd_shr(fb_prod, sfd_pkg::GAIN_FRAC);
  assign fb_new  = sfd_pkg::sat_sample(fb_sum);

  assign og_prod = y_q * $signed({1'b0, out_gain_i});
  assign out_o   = sfd_pkg::sat_sample(sfd_pkg::rnd_shr(og_prod, sfd_pkg::GAIN_FRAC));

  assign sc_prod = rdata_q * $signed({1'b0, coef_i});
  assign scaled  = sfd_pkg::sat_sample(sfd_pkg::rnd_shr(sc_prod, sfd_pkg::GAIN_FRAC));

  assign we = ctrl_i.wr_clr || ctrl_i.wr_fb || ctrl_i.wr_op;

  always_comb begin
    if (ctrl_i.wr_clr) begin
      wdata = '0;
    end else if (ctrl_i.wr_fb) begin
      wdata = fb_new;
    end else if (ctrl_i.op_scale) begin
      wdata = scaled;
    end else begin
      wdata = s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr_i] <= wdata;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_s1) begin
      s1_q <= s1_d;
    end
    if (ctrl_i.ld_acc) begin
      acc_q <= acc_d;
    end
    if (ctrl_i.ld_y) begin
      y_q <= y_d;
    end
  end

endmodule
